// ----- hw/rtl/aqbt_pkg.sv -----
// Package for the quadratic Bezier edge tessellator.
// Holds field widths, multiply-accumulate control types and the cosine table functions.
// No dependencies.
`default_nettype none

package aqbt_pkg;

  localparam int SEG_MAX_DEF = 10;
  localparam int COORD_W     = 24;
  localparam int COL_W       = 32;
  localparam int LBL_W       = 9;
  localparam int IDX_W       = 4;
  localparam int WGT_W       = 17;
  localparam int RED_LIM     = 2048;
  localparam int OP_W        = 25;
  localparam int ACC_W       = 64;
  localparam int LBL_ROUND   = 32768;

  localparam longint ONE_Q30  = 64'sd1073741824;
  localparam longint COS1_Q30 = 64'sd1073211997;

  typedef enum logic [1:0] {
    SH_0,
    SH_16,
    SH_23
  } mac_shift_e;

  typedef struct packed {
    logic       valid;
    logic       clr;
    logic       neg;
    mac_shift_e shift;
  } mac_ctrl_t;

  function automatic longint cos_q30(input int k);
    longint cp;
    longint cc;
    longint cn;
    int     j;
    cp = ONE_Q30;
    cc = COS1_Q30;
    if (k == 0) begin
      return ONE_Q30;
    end
    for (j = 1; j < k; j++) begin
      cn = (2 * COS1_Q30 * cc) / ONE_Q30 - cp;
      cp = cc;
      cc = cn;
    end
    return cc;
  endfunction

  function automatic logic [16:0] cos_sq(input int k);
    longint c;
    c = cos_q30(k);
    return 17'((c * c) >>> 44);
  endfunction

  function automatic logic cos_neg(input int k);
    return cos_q30(k) < 0;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/aqbt_in_if.sv -----
// Input channel of the tessellator: one edge per word.
// Depends on aqbt_pkg for the field widths.
`default_nettype none

interface aqbt_in_if;
  import aqbt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic signed [COORD_W-1:0] control_x;
  logic signed [COORD_W-1:0] control_y;
  logic        [COL_W-1:0]   start_colour;
  logic        [COL_W-1:0]   end_colour;

  modport source (output valid, start_x, start_y, end_x, end_y, control_x, control_y,
                  start_colour, end_colour, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, control_x, control_y,
                start_colour, end_colour, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/aqbt_out_if.sv -----
// Output channel of the tessellator: one curve point per word.
// Depends on aqbt_pkg for the field widths.
`default_nettype none

interface aqbt_out_if;
  import aqbt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic        [COL_W-1:0]   point_colour;
  logic        [IDX_W-1:0]   point_index;
  logic signed [COORD_W-1:0] label_x;
  logic signed [COORD_W-1:0] label_y;
  logic                      last_point;

  modport source (output valid, point_x, point_y, point_colour, point_index, label_x,
                  label_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, point_colour, point_index, label_x,
                label_y, last_point, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/aqbt_cfg_if.sv -----
// Configuration write channel carrying the label position register.
// Depends on aqbt_pkg for the register width.
`default_nettype none

interface aqbt_cfg_if;
  import aqbt_pkg::*;
  logic             valid;
  logic             ready;
  logic [LBL_W-1:0] label_position;

  modport source (output valid, label_position, input ready);
  modport sink (input valid, label_position, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/adaptive_quadratic_bezier_tessellator.sv -----
// Adaptive quadratic Bezier edge tessellator, top level with the sequencer.
// Depends on aqbt_pkg, the three channel interfaces, aqbt_mac and aqbt_div.
//
// Usage: an edge word on in_i (start, end and control points, two colours) is
// accepted when valid and ready are high; ready is high only while the block is idle.
// The block then delivers n+1 point words on out_o, index 0 (end point) first and
// the start point last with last_point set, where n is 1 to MAX_SEGMENTS from the
// angle at the start point. cfg_i is always ready and sets the label position;
// write it only while the block is idle.
// The block first works out the label anchor, then the angle test (skipped when the control
// or end point equals the start point), then each point in turn; the divider yields NUM_W
// quotient bits per point (NUM_W is 34 at ten segments). The shared multiply-accumulate
// unit and the bit-serial divider do this work. The result sits in an output register;
// when the receiver stalls, work on the next point goes on up to that register and then
// waits.
// Reset clears the sequencer and the output valid, and sets the label position to 128.
`default_nettype none

module adaptive_quadratic_bezier_tessellator import aqbt_pkg::*; #(
  parameter int MAX_SEGMENTS = SEG_MAX_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  aqbt_in_if.sink     in_i,
  aqbt_out_if.source  out_o,
  aqbt_cfg_if.sink    cfg_i
);

  localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
  localparam int SQ_W  = 2 * SEG_W;
  localparam int DEN_W = SQ_W + 1;
  localparam int WT_W  = SQ_W + 2;
  localparam int NUM_W = 26 + SQ_W;
  localparam int LANES = 6;

  typedef enum logic [3:0] {
    S_IDLE, S_LBX, S_LBY, S_RED, S_DOT, S_NA, S_NB, S_AB, S_LHS, S_TST,
    S_PTW, S_PX, S_PY, S_PC, S_DIV, S_PUT
  } state_e;

  state_e state_q;
  logic [3:0]       step_q;
  logic [SEG_W-1:0] k_q, n_q, i_q;
  logic [1:0]       ch_q;

  logic signed [COORD_W-1:0] sx_q, sy_q, ex_q, ey_q, cx_q, cy_q;
  logic [COL_W-1:0]          cs_q, ce_q;
  logic [COORD_W-1:0]        amx_q, amy_q, bmx_q, bmy_q;
  logic                      asx_q, asy_q, bsx_q, bsy_q, zero_q;
  logic signed [COORD_W-1:0] lx_q, ly_q, dot_q;
  logic [22:0]               na_q, nb_q;
  logic [45:0]               ab_q;
  logic signed [ACC_W-1:0]   neglhs_q;
  logic [WT_W-1:0]           w_ii_q, w_iu_q, w_uu_q, w_cs_q, w_ce_q;
  logic [DEN_W-1:0]          den_q;
  logic signed [ACC_W-1:0]   init_pt_q;
  logic [NUM_W-1:0]          num_q [LANES];
  logic [WGT_W-1:0]          ws_q, we_q, wc_q;

  logic                      ovalid_q, olast_q;
  logic signed [COORD_W-1:0] opx_q, opy_q, olx_q, oly_q;
  logic [COL_W-1:0]          ocol_q;
  logic [IDX_W-1:0]          oidx_q;

  mac_ctrl_t               mac_ctrl;
  logic signed [OP_W-1:0]  op_a, op_b;
  logic signed [ACC_W-1:0] mac_init, acc;
  logic                    div_start, div_done;
  logic [NUM_W-1:0]        quo [LANES];

  logic [16:0] c2_tab  [MAX_SEGMENTS+1];
  logic        neg_tab [MAX_SEGMENTS+1];

  for (genvar g = 0; g <= MAX_SEGMENTS; g++) begin : g_cos
    assign c2_tab[g]  = cos_sq(g);
    assign neg_tab[g] = cos_neg(g);
  end

  // Input differences: a = start - control, b = start - end.
  logic signed [COORD_W:0] dax, day, dbx, dby;
  assign dax = (COORD_W+1)'(in_i.start_x) - (COORD_W+1)'(in_i.control_x);
  assign day = (COORD_W+1)'(in_i.start_y) - (COORD_W+1)'(in_i.control_y);
  assign dbx = (COORD_W+1)'(in_i.start_x) - (COORD_W+1)'(in_i.end_x);
  assign dby = (COORD_W+1)'(in_i.start_y) - (COORD_W+1)'(in_i.end_y);

  logic signed [11:0] rax, ray, rbx, rby;
  assign rax = asx_q ? -{1'b0, amx_q[10:0]} : {1'b0, amx_q[10:0]};
  assign ray = asy_q ? -{1'b0, amy_q[10:0]} : {1'b0, amy_q[10:0]};
  assign rbx = bsx_q ? -{1'b0, bmx_q[10:0]} : {1'b0, bmx_q[10:0]};
  assign rby = bsy_q ? -{1'b0, bmy_q[10:0]} : {1'b0, bmy_q[10:0]};

  logic a_big, b_big;
  assign a_big = (amx_q >= COORD_W'(RED_LIM)) || (amy_q >= COORD_W'(RED_LIM));
  assign b_big = (bmx_q >= COORD_W'(RED_LIM)) || (bmy_q >= COORD_W'(RED_LIM));

  logic tst_ok;
  assign tst_ok = neg_tab[k_q] ? ((dot_q < 0) && (acc <= 0))
                               : ((dot_q <= 0) || (acc >= 0));

  // Label weights from the written position.
  logic [LBL_W-1:0] cp, cs_w, cq;
  assign cp   = (cfg_i.label_position > LBL_W'(256)) ? LBL_W'(256) : cfg_i.label_position;
  assign cs_w = (cp <= LBL_W'(128)) ? cp : LBL_W'(256) - cp;
  assign cq   = LBL_W'(256) - cs_w;
  assign cfg_i.ready = 1'b1;

  // Per-point weights.
  logic [SEG_W-1:0] u_v;
  logic [SQ_W-1:0]  ii_v, iu_v, uu_v, in_v, un_v, nn_v;
  assign u_v  = n_q - i_q;
  assign ii_v = SQ_W'(i_q) * SQ_W'(i_q);
  assign iu_v = SQ_W'(i_q) * SQ_W'(u_v);
  assign uu_v = SQ_W'(u_v) * SQ_W'(u_v);
  assign in_v = SQ_W'(i_q) * SQ_W'(n_q);
  assign un_v = SQ_W'(u_v) * SQ_W'(n_q);
  assign nn_v = SQ_W'(n_q) * SQ_W'(n_q);

  logic [7:0] cs_byte, ce_byte;
  assign cs_byte = cs_q[{ch_q, 3'b000} +: 8];
  assign ce_byte = ce_q[{ch_q, 3'b000} +: 8];

  always_comb begin
    mac_ctrl = '0;
    op_a     = '0;
    op_b     = '0;
    mac_init = '0;
    case (state_q)
      S_LBX, S_LBY: begin
        mac_ctrl.valid = step_q < 4'd3;
        mac_ctrl.clr   = step_q == 4'd0;
        mac_init       = ACC_W'(LBL_ROUND);
        case (step_q)
          4'd0: begin
            op_a = OP_W'(state_q == S_LBX ? sx_q : sy_q);
            op_b = OP_W'(ws_q);
          end
          4'd1: begin
            op_a = OP_W'(state_q == S_LBX ? ex_q : ey_q);
            op_b = OP_W'(we_q);
          end
          default: begin
            op_a = OP_W'(state_q == S_LBX ? cx_q : cy_q);
            op_b = OP_W'(wc_q);
          end
        endcase
      end
      S_DOT, S_NA, S_NB: begin
        mac_ctrl.valid = step_q < 4'd2;
        mac_ctrl.clr   = step_q == 4'd0;
        if (state_q == S_DOT) begin
          op_a = OP_W'(step_q == 4'd0 ? rax : ray);
          op_b = OP_W'(step_q == 4'd0 ? rbx : rby);
        end else if (state_q == S_NA) begin
          op_a = OP_W'(step_q == 4'd0 ? rax : ray);
          op_b = op_a;
        end else begin
          op_a = OP_W'(step_q == 4'd0 ? rbx : rby);
          op_b = op_a;
        end
      end
      S_AB: begin
        mac_ctrl.valid = step_q == 4'd0;
        mac_ctrl.clr   = 1'b1;
        op_a = OP_W'(na_q);
        op_b = OP_W'(nb_q);
      end
      S_LHS: begin
        mac_ctrl.valid = step_q == 4'd0;
        mac_ctrl.clr   = 1'b1;
        mac_ctrl.neg   = 1'b1;
        mac_ctrl.shift = SH_16;
        op_a = OP_W'(dot_q);
        op_b = OP_W'(dot_q);
      end
      S_TST: begin
        mac_ctrl.valid = step_q < 4'd2;
        mac_ctrl.clr   = step_q == 4'd0;
        mac_ctrl.shift = (step_q == 4'd0) ? SH_0 : SH_23;
        mac_init       = neglhs_q;
        op_a = OP_W'(c2_tab[k_q]);
        op_b = OP_W'(step_q == 4'd0 ? ab_q[22:0] : ab_q[45:23]);
      end
      S_PX, S_PY: begin
        mac_ctrl.valid = step_q < 4'd3;
        mac_ctrl.clr   = step_q == 4'd0;
        mac_init       = init_pt_q;
        case (step_q)
          4'd0: begin
            op_a = OP_W'(state_q == S_PX ? sx_q : sy_q);
            op_b = OP_W'(w_ii_q);
          end
          4'd1: begin
            op_a = OP_W'(state_q == S_PX ? cx_q : cy_q);
            op_b = OP_W'(w_iu_q);
          end
          default: begin
            op_a = OP_W'(state_q == S_PX ? ex_q : ey_q);
            op_b = OP_W'(w_uu_q);
          end
        endcase
      end
      S_PC: begin
        mac_ctrl.valid = step_q < 4'd2;
        mac_ctrl.clr   = step_q == 4'd0;
        mac_init       = init_pt_q;
        op_a = OP_W'(step_q == 4'd0 ? cs_byte : ce_byte);
        op_b = OP_W'(step_q == 4'd0 ? w_cs_q : w_ce_q);
      end
      default: begin
      end
    endcase
  end

  assign div_start = (state_q == S_DIV) && (step_q == 4'd0);

  aqbt_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (op_a),
    .b_i    (op_b),
    .init_i (mac_init),
    .acc_o  (acc)
  );

  aqbt_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .LANES (LANES)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .den_i   (den_q),
    .num_i   (num_q),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  logic put_go;
  assign put_go = (state_q == S_PUT) && (!ovalid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= '0;
      k_q      <= '0;
      n_q      <= '0;
      i_q      <= '0;
      ch_q     <= '0;
      ovalid_q <= 1'b0;
      ws_q     <= WGT_W'(16384);
      we_q     <= WGT_W'(16384);
      wc_q     <= WGT_W'(32768);
    end else begin
      if (cfg_i.valid) begin
        ws_q <= WGT_W'(cq * (LBL_W'(256) - cp));
        we_q <= WGT_W'(cq * cp);
        wc_q <= {cs_w, 8'd0};
      end
      if (put_go) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            sx_q   <= in_i.start_x;
            sy_q   <= in_i.start_y;
            ex_q   <= in_i.end_x;
            ey_q   <= in_i.end_y;
            cx_q   <= in_i.control_x;
            cy_q   <= in_i.control_y;
            cs_q   <= in_i.start_colour;
            ce_q   <= in_i.end_colour;
            asx_q  <= dax[COORD_W];
            asy_q  <= day[COORD_W];
            bsx_q  <= dbx[COORD_W];
            bsy_q  <= dby[COORD_W];
            amx_q  <= COORD_W'(dax[COORD_W] ? -dax : dax);
            amy_q  <= COORD_W'(day[COORD_W] ? -day : day);
            bmx_q  <= COORD_W'(dbx[COORD_W] ? -dbx : dbx);
            bmy_q  <= COORD_W'(dby[COORD_W] ? -dby : dby);
            zero_q <= ((dax == '0) && (day == '0)) || ((dbx == '0) && (dby == '0));
            step_q <= '0;
            state_q <= S_LBX;
          end
        end
        S_LBX: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd4) begin
            lx_q    <= acc[39:16];
            step_q  <= '0;
            state_q <= S_LBY;
          end
        end
        S_LBY: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd4) begin
            ly_q   <= acc[39:16];
            step_q <= '0;
            n_q    <= SEG_W'(1);
            i_q    <= '0;
            state_q <= zero_q ? S_PTW : S_RED;
          end
        end
        S_RED: begin
          if (a_big) begin
            amx_q <= amx_q >> 1;
            amy_q <= amy_q >> 1;
          end
          if (b_big) begin
            bmx_q <= bmx_q >> 1;
            bmy_q <= bmy_q >> 1;
          end
          if (!a_big && !b_big) begin
            state_q <= S_DOT;
          end
        end
        S_DOT: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd3) begin
            dot_q   <= acc[COORD_W-1:0];
            step_q  <= '0;
            state_q <= S_NA;
          end
        end
        S_NA: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd3) begin
            na_q    <= acc[22:0];
            step_q  <= '0;
            state_q <= S_NB;
          end
        end
        S_NB: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd3) begin
            nb_q    <= acc[22:0];
            step_q  <= '0;
            state_q <= S_AB;
          end
        end
        S_AB: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd2) begin
            ab_q    <= acc[45:0];
            step_q  <= '0;
            state_q <= S_LHS;
          end
        end
        S_LHS: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd2) begin
            neglhs_q <= acc;
            step_q   <= '0;
            k_q      <= SEG_W'(1);
            state_q  <= S_TST;
          end
        end
        S_TST: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd3) begin
            step_q <= '0;
            if (tst_ok) begin
              n_q <= k_q;
            end
            if (tst_ok && (k_q != SEG_W'(MAX_SEGMENTS))) begin
              k_q <= k_q + SEG_W'(1);
            end else begin
              i_q     <= '0;
              state_q <= S_PTW;
            end
          end
        end
        S_PTW: begin
          w_ii_q    <= WT_W'({ii_v, 1'b0});
          w_iu_q    <= WT_W'({iu_v, 2'b00});
          w_uu_q    <= WT_W'({uu_v, 1'b0});
          w_cs_q    <= WT_W'({in_v, 1'b0});
          w_ce_q    <= WT_W'({un_v, 1'b0});
          den_q     <= {nn_v, 1'b0};
          init_pt_q <= ACC_W'(nn_v) + (ACC_W'(nn_v) << 25);
          step_q    <= '0;
          state_q   <= S_PX;
        end
        S_PX: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd4) begin
            num_q[0] <= acc[NUM_W-1:0];
            step_q   <= '0;
            state_q  <= S_PY;
          end
        end
        S_PY: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd4) begin
            num_q[1] <= acc[NUM_W-1:0];
            step_q   <= '0;
            ch_q     <= '0;
            state_q  <= S_PC;
          end
        end
        S_PC: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd3) begin
            num_q[3'(ch_q) + 3'd2] <= acc[NUM_W-1:0];
            step_q <= '0;
            ch_q   <= ch_q + 2'd1;
            if (ch_q == 2'd3) begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (step_q == 4'd0) begin
            step_q <= 4'd1;
          end
          if (div_done) begin
            step_q  <= '0;
            state_q <= S_PUT;
          end
        end
        S_PUT: begin
          if (put_go) begin
            opx_q   <= quo[0][COORD_W-1:0];
            opy_q   <= quo[1][COORD_W-1:0];
            ocol_q  <= {quo[5][7:0], quo[4][7:0], quo[3][7:0], quo[2][7:0]};
            oidx_q  <= IDX_W'(i_q);
            olx_q   <= lx_q;
            oly_q   <= ly_q;
            olast_q <= i_q == n_q;
            if (i_q == n_q) begin
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q + SEG_W'(1);
              state_q <= S_PTW;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready         = state_q == S_IDLE;
  assign out_o.valid        = ovalid_q;
  assign out_o.point_x      = opx_q;
  assign out_o.point_y      = opy_q;
  assign out_o.point_colour = ocol_q;
  assign out_o.point_index  = oidx_q;
  assign out_o.label_x      = olx_q;
  assign out_o.label_y      = oly_q;
  assign out_o.last_point   = olast_q;

`ifndef SYNTH
  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PTW) |-> (n_q >= SEG_W'(1)) && (n_q <= SEG_W'(MAX_SEGMENTS)) && (i_q <= n_q))
    else $error("segment count or point index out of range");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide step");
  a_mac_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mac_ctrl.valid)
    else $error("multiply-accumulate issued while idle");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/aqbt_mac.sv -----
// Shared two-stage signed multiply-accumulate unit with a shifted, optionally negated term.
// Depends on aqbt_pkg for the control struct and widths.
`default_nettype none

module aqbt_mac import aqbt_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire mac_ctrl_t               ctrl_i,
  input  wire logic signed [OP_W-1:0]  a_i,
  input  wire logic signed [OP_W-1:0]  b_i,
  input  wire logic signed [ACC_W-1:0] init_i,
  output logic signed [ACC_W-1:0]      acc_o
);

  mac_ctrl_t                  ctrl_q;
  logic signed [2*OP_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    init_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [ACC_W-1:0]    term;
  logic signed [ACC_W-1:0]    base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    init_q <= init_i;
    if (ctrl_q.valid) begin
      acc_q <= base + (ctrl_q.neg ? -term : term);
    end
  end

  always_comb begin
    unique case (ctrl_q.shift)
      SH_16:   term = ACC_W'(prod_q) <<< 16;
      SH_23:   term = ACC_W'(prod_q) <<< 23;
      default: term = ACC_W'(prod_q);
    endcase
    base = ctrl_q.clr ? init_q : acc_q;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ----- hw/rtl/aqbt_div.sv -----
// Bit-serial restoring divider with several numerator lanes sharing one divisor.
// Depends on aqbt_pkg only through the import convention.
`default_nettype none

module aqbt_div import aqbt_pkg::*; #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 9,
  parameter int LANES = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic [NUM_W-1:0] num_i [LANES],
  output logic      [NUM_W-1:0] quo_o [LANES],
  output logic                  done_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] sh_q  [LANES];
  logic [DEN_W-1:0] rem_q [LANES];
  logic [DEN_W:0]   trial [LANES];
  logic             qbit  [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      trial[l] = {rem_q[l], sh_q[l][NUM_W-1]};
      qbit[l]  = trial[l] >= {1'b0, den_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      for (int l = 0; l < LANES; l++) begin
        sh_q[l]  <= num_i[l];
        rem_q[l] <= '0;
      end
    end else if (busy_q) begin
      for (int l = 0; l < LANES; l++) begin
        sh_q[l]  <= {sh_q[l][NUM_W-2:0], qbit[l]};
        rem_q[l] <= qbit[l] ? DEN_W'(trial[l] - {1'b0, den_q}) : DEN_W'(trial[l]);
      end
    end
  end

  assign quo_o  = sh_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- tb/sv/adaptive_quadratic_bezier_tessellator_checker.sv -----
// Checker for the quadratic Bezier edge tessellator: predicts every point word.
// Watches the edge, point and configuration channels; depends on aqbt_pkg and the interfaces.
`timescale 1ns / 1ps

module adaptive_quadratic_bezier_tessellator_checker import aqbt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aqbt_in_if.sink   edge_mon,
  aqbt_out_if.sink  point_mon,
  aqbt_cfg_if.sink  cfg_mon,
  output int        fail_count_o,
  output int        pending_o
);

  typedef struct {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [COL_W-1:0]          col;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] lx;
    logic signed [COORD_W-1:0] ly;
    logic                      last;
  } point_t;

  point_t    point_q[$];
  logic [LBL_W-1:0] lbl_reg;

  assign pending_o = point_q.size();

  function automatic longint rnd_div(longint num, longint d);
    longint n2;
    longint dd;
    longint qv;
    n2 = num * 2 + d;
    dd = d * 2;
    qv = n2 / dd;
    if ((n2 % dd) != 0 && n2 < 0) qv--;
    return qv;
  endfunction

  function automatic longint iabs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void shrink(inout longint x, inout longint y);
    longint mx;
    longint my;
    mx = iabs(x);
    my = iabs(y);
    while (mx >= RED_LIM || my >= RED_LIM) begin
      mx = mx / 2;
      my = my / 2;
    end
    x = (x < 0) ? -mx : mx;
    y = (y < 0) ? -my : my;
  endfunction

  function automatic int segments(longint ax, longint ay, longint bx, longint by);
    longint dot;
    longint cp;
    longint cc;
    longint cn;
    logic [63:0] lhs;
    logic [63:0] ab;
    logic [63:0] c2;
    int n;
    bit ok;
    if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) return 1;
    shrink(ax, ay);
    shrink(bx, by);
    dot = ax * bx + ay * by;
    lhs = 64'(dot * dot) << 16;
    ab = 64'(ax * ax + ay * ay) * 64'(bx * bx + by * by);
    cp = ONE_Q30;
    cc = COS1_Q30;
    n = 0;
    for (int k = 1; k <= SEG_MAX_DEF; k++) begin
      c2 = 64'(cc * cc) >> 44;
      if (cc >= 0) ok = (dot <= 0) || (lhs <= c2 * ab);
      else ok = (dot < 0) && (lhs >= c2 * ab);
      if (!ok) break;
      n = k;
      cn = (2 * COS1_Q30 * cc) / ONE_Q30 - cp;
      cp = cc;
      cc = cn;
    end
    return n < 1 ? 1 : n;
  endfunction

  task automatic predict_points();
    longint sx, sy, ex, ey, cx, cy, p, s, q, lx, ly, ti, ui, d, a, b, v;
    logic [COL_W-1:0] cs, ce;
    int n;
    point_t pt;
    sx = edge_mon.start_x;   sy = edge_mon.start_y;
    ex = edge_mon.end_x;     ey = edge_mon.end_y;
    cx = edge_mon.control_x; cy = edge_mon.control_y;
    cs = edge_mon.start_colour;
    ce = edge_mon.end_colour;
    p = lbl_reg;
    if (p > 256) p = 256;
    s = 128 - iabs(p - 128);
    q = 256 - s;
    lx = rnd_div(sx * q * (256 - p) + ex * q * p + cx * 256 * s, 65536);
    ly = rnd_div(sy * q * (256 - p) + ey * q * p + cy * 256 * s, 65536);
    n = segments(sx - cx, sy - cy, sx - ex, sy - ey);
    for (int i = 0; i <= n; i++) begin
      ti = i;
      ui = n - i;
      d = n * n;
      pt.px = COORD_W'(rnd_div(sx * ti * ti + 2 * cx * ti * ui + ex * ui * ui, d));
      pt.py = COORD_W'(rnd_div(sy * ti * ti + 2 * cy * ti * ui + ey * ui * ui, d));
      for (int ch = 0; ch < 4; ch++) begin
        a = cs[ch*8 +: 8];
        b = ce[ch*8 +: 8];
        v = ((a * ti + b * ui) * 2 + n) / (2 * n);
        pt.col[ch*8 +: 8] = 8'(v);
      end
      pt.idx = IDX_W'(i);
      pt.lx = COORD_W'(lx);
      pt.ly = COORD_W'(ly);
      pt.last = (i == n);
      point_q = {point_q, pt};
    end
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_t e;
    if (!rst_ni) begin
      lbl_reg <= 9'd128;
      fail_count_o = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) lbl_reg <= cfg_mon.label_position;
      if (edge_mon.valid && edge_mon.ready) predict_points();
      if (point_mon.valid && point_mon.ready) begin
        if (point_q.size() == 0) begin
          report_mismatch("point word with none expected");
        end else begin
          e = point_q.pop_front();
          if (point_mon.point_x !== e.px)
            report_mismatch($sformatf("point_x %h exp %h", point_mon.point_x, e.px));
          if (point_mon.point_y !== e.py)
            report_mismatch($sformatf("point_y %h exp %h", point_mon.point_y, e.py));
          if (point_mon.point_colour !== e.col)
            report_mismatch($sformatf("colour %h exp %h", point_mon.point_colour, e.col));
          if (point_mon.point_index !== e.idx)
            report_mismatch($sformatf("index %0d exp %0d", point_mon.point_index, e.idx));
          if (point_mon.label_x !== e.lx)
            report_mismatch($sformatf("label_x %h exp %h", point_mon.label_x, e.lx));
          if (point_mon.label_y !== e.ly)
            report_mismatch($sformatf("label_y %h exp %h", point_mon.label_y, e.ly));
          if (point_mon.last_point !== e.last)
            report_mismatch($sformatf("last %b exp %b", point_mon.last_point, e.last));
        end
      end
    end
  end

endmodule

// ----- tb/sv/adaptive_quadratic_bezier_tessellator_tb.sv -----
// Top of the tessellator testbench: clock, reset, edge and register stimulus, verdict.
// Depends on aqbt_pkg, the channel interfaces, the block and its checker.
`timescale 1ns / 1ps

module adaptive_quadratic_bezier_tessellator_tb;
  import aqbt_pkg::*;

  localparam int WATCH_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;
  bit   busy_stretch = 0;

  aqbt_in_if  edge_ch ();
  aqbt_out_if point_ch ();
  aqbt_cfg_if cfg_ch ();

  adaptive_quadratic_bezier_tessellator uut (
    .clk_i (clk_i), .rst_ni(rst_ni), .in_i(edge_ch), .out_o(point_ch), .cfg_i(cfg_ch)
  );

  adaptive_quadratic_bezier_tessellator_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .edge_mon(edge_ch), .point_mon(point_ch),
    .cfg_mon(cfg_ch), .fail_count_o(fail_count), .pending_o(pending)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    edge_ch.valid = 1'b0;
    edge_ch.start_x = '0; edge_ch.start_y = '0;
    edge_ch.end_x = '0; edge_ch.end_y = '0;
    edge_ch.control_x = '0; edge_ch.control_y = '0;
    edge_ch.start_colour = '0; edge_ch.end_colour = '0;
    point_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.label_position = '0;
  end

  always @(posedge clk_i) begin
    point_ch.ready <= busy_stretch || ($urandom_range(99) >= 18);
  end

  always @(posedge clk_i) begin
    if ((edge_ch.valid && edge_ch.ready) || (point_ch.valid && point_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCH_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_label(logic [LBL_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.label_position <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_edge(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                           logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey,
                           logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                           logic [COL_W-1:0] cs, logic [COL_W-1:0] ce);
    while (!busy_stretch && $urandom_range(99) < 18) begin
      edge_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    edge_ch.valid <= 1'b1;
    edge_ch.start_x <= sx; edge_ch.start_y <= sy;
    edge_ch.end_x <= ex; edge_ch.end_y <= ey;
    edge_ch.control_x <= cx; edge_ch.control_y <= cy;
    edge_ch.start_colour <= cs; edge_ch.end_colour <= ce;
    do @(posedge clk_i); while (!edge_ch.ready);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord(int shape);
    case (shape)
      0: return COORD_W'($urandom);
      1: return COORD_W'($signed($urandom_range(4000)) - 2000);
      default: return COORD_W'($signed($urandom_range(400000)) - 200000);
    endcase
  endfunction

  task automatic random_edge();
    int shape;
    logic [COORD_W-1:0] sx, sy, ex, ey;
    shape = $urandom_range(2);
    sx = rand_coord(shape);
    sy = rand_coord(shape);
    ex = rand_coord(shape);
    ey = rand_coord(shape);
    case ($urandom_range(9))
      0: send_edge(sx, sy, ex, ey, sx, sy, $urandom, $urandom);
      1: send_edge(sx, sy, sx, sy, rand_coord(shape), rand_coord(shape), $urandom, $urandom);
      2: send_edge(sx, sy, ex, ey, COORD_W'(sx + (sx - ex)), COORD_W'(sy + (sy - ey)),
                   $urandom, $urandom);
      default: send_edge(sx, sy, ex, ey, rand_coord(shape), rand_coord(shape),
                         $urandom, $urandom);
    endcase
  endtask

  task automatic wait_idle();
    edge_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  localparam logic [COORD_W-1:0] CMAX = 24'h7FFFFF;
  localparam logic [COORD_W-1:0] CMIN = 24'h800000;

  initial begin
    logic [LBL_W-1:0] label_set[5];
    label_set = '{9'd0, 9'd256, 9'd511, 9'd64, 9'd200};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_edge(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, 32'hFFFFFFFF, 32'h00000000);
    send_edge(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, 32'h00000000, 32'hFFFFFFFF);
    send_edge(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 32'h12345678, 32'h9ABCDEF0);
    send_edge(24'd100, 24'd0, 24'd0, 24'd0, 24'd100, 24'd0, 32'hFF00FF00, 32'h00FF00FF);
    send_edge(24'd100, 24'd0, 24'd100, 24'd0, 24'd0, 24'd0, 32'h01010101, 32'hFEFEFEFE);
    send_edge(24'd1000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd10, 32'h80808080, 32'h7F7F7F7F);
    send_edge(24'd1000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd1000, 32'hAAAAAAAA, 32'h55555555);
    send_edge(24'd1000, 24'd0, 24'd0, 24'd0, 24'd2000, 24'd0, 32'h0F0F0F0F, 32'hF0F0F0F0);
    send_edge(24'd1000, 24'd0, 24'd0, 24'd0, 24'd900, 24'd100, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_edge(24'd1000, 24'd0, 24'd0, 24'd0, 24'd950, 24'd20, 32'h00000001, 32'h00000000);
    send_edge(CMAX, 24'd0, CMIN, 24'd0, 24'd0, CMAX, 32'hDEADBEEF, 32'hCAFEF00D);
    wait_idle();
    for (int ph = 0; ph < 5; ph++) begin
      write_label(label_set[ph]);
      busy_stretch = (ph == 2);
      for (int k = 0; k < 20; k++) random_edge();
      wait_idle();
    end
    write_label(9'd128);
    send_edge(24'd5000, 24'hFFF000, CMIN, 24'd77, 24'd3, CMAX, $urandom, $urandom);
    wait_idle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
